// ===== hdl/abt_pkg.sv =====
// shared constants and codes for the box build, transform and overlap block
package abt_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  localparam int FUNC_W = 2;
  localparam int AXIS_W = 2;
  localparam int NUM_AXES = 3;

  // function codes, code 3 is unused and does nothing
  typedef enum logic [FUNC_W-1:0] {
    FUNC_VERTEX = 2'd0,
    FUNC_XFORM  = 2'd1,
    FUNC_TEST   = 2'd2
  } func_e;

  // output axis codes of a transform item
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

endpackage

// ===== hdl/abt_qmul.sv =====
// fixed-point product, floor of the scaled product, saturated to the coordinate range
module abt_qmul #(
  parameter int COORD_WIDTH = abt_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = abt_pkg::DEF_FRAC_BITS
) (
  input  logic signed [COORD_WIDTH-1:0] a_i,
  input  logic signed [COORD_WIDTH-1:0] b_i,
  output logic signed [COORD_WIDTH-1:0] p_o
);

  localparam int PW = 2 * COORD_WIDTH;
  localparam logic signed [PW-1:0] SMAX =
    $signed({{(PW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [PW-1:0] SMIN = ~SMAX;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] quot;

  assign prod = PW'(a_i) * PW'(b_i);
  // arithmetic shift rounds toward minus infinity
  assign quot = prod >>> FRAC_BITS;

  always_comb begin
    if (quot > SMAX) begin
      p_o = SMAX[COORD_WIDTH-1:0];
    end else if (quot < SMIN) begin
      p_o = SMIN[COORD_WIDTH-1:0];
    end else begin
      p_o = quot[COORD_WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/abt_axis_xform.sv =====
// one output axis of an affine map applied to a box, min/max product sum
module abt_axis_xform #(
  parameter int COORD_WIDTH = abt_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = abt_pkg::DEF_FRAC_BITS
) (
  input  logic signed [COORD_WIDTH-1:0] coef_i  [abt_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] trans_i,
  input  logic signed [COORD_WIDTH-1:0] omin_i  [abt_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] omax_i  [abt_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH-1:0] lo_o,
  output logic signed [COORD_WIDTH-1:0] hi_o
);

  // four terms need two guard bits
  localparam int SW = COORD_WIDTH + 2;
  localparam logic signed [SW-1:0] SMAX =
    $signed({3'b000, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  logic signed [COORD_WIDTH-1:0] e [abt_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] f [abt_pkg::NUM_AXES];
  logic signed [SW-1:0] lo_sum;
  logic signed [SW-1:0] hi_sum;

  for (genvar j = 0; j < abt_pkg::NUM_AXES; j++) begin : g_term
    abt_qmul #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_mul_min (
      .a_i(coef_i[j]),
      .b_i(omin_i[j]),
      .p_o(e[j])
    );
    abt_qmul #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_mul_max (
      .a_i(coef_i[j]),
      .b_i(omax_i[j]),
      .p_o(f[j])
    );
  end

  always_comb begin
    lo_sum = SW'(trans_i);
    hi_sum = SW'(trans_i);
    for (int j = 0; j < abt_pkg::NUM_AXES; j++) begin
      if (e[j] < f[j]) begin
        lo_sum = lo_sum + SW'(e[j]);
        hi_sum = hi_sum + SW'(f[j]);
      end else begin
        lo_sum = lo_sum + SW'(f[j]);
        hi_sum = hi_sum + SW'(e[j]);
      end
    end
  end

  always_comb begin
    if (lo_sum > SMAX) begin
      lo_o = SMAX[COORD_WIDTH-1:0];
    end else if (lo_sum < SMIN) begin
      lo_o = SMIN[COORD_WIDTH-1:0];
    end else begin
      lo_o = lo_sum[COORD_WIDTH-1:0];
    end
    if (hi_sum > SMAX) begin
      hi_o = SMAX[COORD_WIDTH-1:0];
    end else if (hi_sum < SMIN) begin
      hi_o = SMIN[COORD_WIDTH-1:0];
    end else begin
      hi_o = hi_sum[COORD_WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/aabb_build_transform_overlap.sv =====
// top level: axis-aligned box build, affine transform and overlap test
//
// input channel (in_valid_i / in_ready_o) takes one item per cycle while in_ready_o is high:
//   vertex items fold v0..v2 into the box under construction, first_vertex
//   restarts it, last_vertex commits it to the current box and the original
//   transform items rebuild one axis of the current box from the original
//   test items compare box v0..v2 (min) / v3..v5 (max) against the current box
// output channel (out_valid_o / out_ready_i) returns one item for every
//   input item: the current box after that item, plus the overlap flag
// each item passes an input register, then one pass of products,
//   sums and compares into the result register
// throughput is one item per cycle unless the receiver stalls; the six coordinate
//   multipliers of the transform and the sum after them set the cycle time
// box state advances when an item moves from the input register to the
//   result register, so the next item always sees the updated box
// reset clears all boxes to zero and empties both registers
// when the receiver stalls the result register holds, the input register
//   fills, and in_ready_o drops only while both are full
module aabb_build_transform_overlap #(
  parameter int COORD_WIDTH = abt_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = abt_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [abt_pkg::FUNC_W-1:0]    func_i,
  input  logic                          first_vertex_i,
  input  logic                          last_vertex_i,
  input  logic [abt_pkg::AXIS_W-1:0]    axis_i,
  input  logic signed [COORD_WIDTH-1:0] v0_i,
  input  logic signed [COORD_WIDTH-1:0] v1_i,
  input  logic signed [COORD_WIDTH-1:0] v2_i,
  input  logic signed [COORD_WIDTH-1:0] v3_i,
  input  logic signed [COORD_WIDTH-1:0] v4_i,
  input  logic signed [COORD_WIDTH-1:0] v5_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          overlap_o,
  output logic signed [COORD_WIDTH-1:0] box_min_x_o,
  output logic signed [COORD_WIDTH-1:0] box_min_y_o,
  output logic signed [COORD_WIDTH-1:0] box_min_z_o,
  output logic signed [COORD_WIDTH-1:0] box_max_x_o,
  output logic signed [COORD_WIDTH-1:0] box_max_y_o,
  output logic signed [COORD_WIDTH-1:0] box_max_z_o
);

  localparam int NA = abt_pkg::NUM_AXES;

  // input register
  logic                          in_vld_q;
  logic [abt_pkg::FUNC_W-1:0]    func_q;
  logic                          first_q;
  logic                          last_q;
  logic [abt_pkg::AXIS_W-1:0]    axis_q;
  logic signed [COORD_WIDTH-1:0] vmin_q [NA];  // v0..v2
  logic signed [COORD_WIDTH-1:0] vmax_q [NA];  // v3..v5

  // box state
  logic signed [COORD_WIDTH-1:0] cur_min_q [NA], cur_min_d [NA];
  logic signed [COORD_WIDTH-1:0] cur_max_q [NA], cur_max_d [NA];
  logic signed [COORD_WIDTH-1:0] orig_min_q [NA], orig_min_d [NA];
  logic signed [COORD_WIDTH-1:0] orig_max_q [NA], orig_max_d [NA];
  logic signed [COORD_WIDTH-1:0] bld_min_q [NA], bld_min_d [NA];
  logic signed [COORD_WIDTH-1:0] bld_max_q [NA], bld_max_d [NA];

  // result register
  logic                          out_vld_q;
  logic                          ovl_q, ovl_d;
  logic signed [COORD_WIDTH-1:0] res_min_q [NA];
  logic signed [COORD_WIDTH-1:0] res_max_q [NA];

  logic in_take;
  logic advance;
  logic signed [COORD_WIDTH-1:0] xf_lo;
  logic signed [COORD_WIDTH-1:0] xf_hi;

  // an item moves on whenever the result register is free or draining
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q    <= func_i;
      first_q   <= first_vertex_i;
      last_q    <= last_vertex_i;
      axis_q    <= axis_i;
      vmin_q[0] <= v0_i;
      vmin_q[1] <= v1_i;
      vmin_q[2] <= v2_i;
      vmax_q[0] <= v3_i;
      vmax_q[1] <= v4_i;
      vmax_q[2] <= v5_i;
    end
  end

  // transform item: coefficients in v0..v2, translation in v3
  abt_axis_xform #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_xform (
    .coef_i (vmin_q),
    .trans_i(vmax_q[0]),
    .omin_i (orig_min_q),
    .omax_i (orig_max_q),
    .lo_o   (xf_lo),
    .hi_o   (xf_hi)
  );

  always_comb begin
    cur_min_d  = cur_min_q;
    cur_max_d  = cur_max_q;
    orig_min_d = orig_min_q;
    orig_max_d = orig_max_q;
    bld_min_d  = bld_min_q;
    bld_max_d  = bld_max_q;
    ovl_d      = 1'b0;
    if (advance) begin
      case (func_q)
        abt_pkg::FUNC_VERTEX: begin
          for (int i = 0; i < NA; i++) begin
            if (first_q) begin
              bld_min_d[i] = vmin_q[i];
              bld_max_d[i] = vmin_q[i];
            end else begin
              if (vmin_q[i] < bld_min_q[i]) bld_min_d[i] = vmin_q[i];
              if (vmin_q[i] > bld_max_q[i]) bld_max_d[i] = vmin_q[i];
            end
          end
          // commit includes this vertex
          if (last_q) begin
            cur_min_d  = bld_min_d;
            cur_max_d  = bld_max_d;
            orig_min_d = bld_min_d;
            orig_max_d = bld_max_d;
          end
        end
        abt_pkg::FUNC_XFORM: begin
          // an out-of-range axis leaves the box alone
          if (axis_q inside {abt_pkg::AXIS_X, abt_pkg::AXIS_Y, abt_pkg::AXIS_Z}) begin
            cur_min_d[axis_q] = xf_lo;
            cur_max_d[axis_q] = xf_hi;
          end
        end
        abt_pkg::FUNC_TEST: begin
          // touching faces count as overlap
          ovl_d = 1'b1;
          for (int i = 0; i < NA; i++) begin
            if (cur_max_q[i] < vmin_q[i] || cur_min_q[i] > vmax_q[i]) ovl_d = 1'b0;
          end
        end
        default: begin
          ovl_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NA; i++) begin
        cur_min_q[i]  <= '0;
        cur_max_q[i]  <= '0;
        orig_min_q[i] <= '0;
        orig_max_q[i] <= '0;
        bld_min_q[i]  <= '0;
        bld_max_q[i]  <= '0;
      end
    end else begin
      cur_min_q  <= cur_min_d;
      cur_max_q  <= cur_max_d;
      orig_min_q <= orig_min_d;
      orig_max_q <= orig_max_d;
      bld_min_q  <= bld_min_d;
      bld_max_q  <= bld_max_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  // result payload is the box after this item
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ovl_q     <= ovl_d;
      res_min_q <= cur_min_d;
      res_max_q <= cur_max_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign overlap_o   = ovl_q;
  assign box_min_x_o = res_min_q[0];
  assign box_min_y_o = res_min_q[1];
  assign box_min_z_o = res_min_q[2];
  assign box_max_x_o = res_max_q[0];
  assign box_max_y_o = res_max_q[1];
  assign box_max_z_o = res_max_q[2];

endmodule

// ===== hdl/abt_checker.sv =====
// port-level checks for the box build, transform and overlap block
module abt_checker #(
  parameter int COORD_WIDTH = abt_pkg::DEF_COORD_WIDTH
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          overlap_o,
  input logic signed [COORD_WIDTH-1:0] box_min_x_o,
  input logic signed [COORD_WIDTH-1:0] box_min_y_o,
  input logic signed [COORD_WIDTH-1:0] box_min_z_o,
  input logic signed [COORD_WIDTH-1:0] box_max_x_o,
  input logic signed [COORD_WIDTH-1:0] box_max_y_o,
  input logic signed [COORD_WIDTH-1:0] box_max_z_o
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(overlap_o)
      && $stable(box_min_x_o) && $stable(box_min_y_o) && $stable(box_min_z_o)
      && $stable(box_max_x_o) && $stable(box_max_y_o) && $stable(box_max_z_o))
    else $error("stalled result changed");

  // with an empty result register the input side never blocks
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result register");

  // every accepted item shows a valid result once it has passed the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("no result two cycles after an accepted item");

endmodule

bind aabb_build_transform_overlap abt_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_abt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .overlap_o  (overlap_o),
  .box_min_x_o(box_min_x_o),
  .box_min_y_o(box_min_y_o),
  .box_min_z_o(box_min_z_o),
  .box_max_x_o(box_max_x_o),
  .box_max_y_o(box_max_y_o),
  .box_max_z_o(box_max_z_o)
);
